@@ rtl/ibpm_pkg.sv @@
// Package for the I2C bit-phase master: command codes, item structs and phase tables.
// No dependencies; imported by every module of the block except ibpm_fifo.
package ibpm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  // APB register map (byte address bit 2 selects the register word)
  localparam logic REG_PHASE_TICKS = 1'b0;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
    logic       rejected;
  } out_item_t;

  // classified request as queued between front and back
  typedef struct packed {
    logic       is_cmd;
    cmd_e       cmd;
    logic [7:0] write_byte;
    logic       ack_to_send;
    logic       sda_in;
  } cls_item_t;

  // front/back queue handshake
  typedef struct packed {
    logic valid;
  } q_ctl_t;

  // index of the final phase of each command
  function automatic logic [4:0] last_phase(cmd_e cmd);
    logic [4:0] res;
    unique case (cmd)
      CMD_START: res = 5'd3;
      CMD_STOP:  res = 5'd2;
      CMD_SEND:  res = 5'(3 * BITS_PER_BYTE - 1);
      CMD_RECV:  res = 5'(3 * BITS_PER_BYTE);
      CMD_SACK:  res = 5'd2;
      CMD_RACK:  res = 5'd3;
      default:   res = 5'd0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/ibpm_fifo.sv @@
// Small register-based FIFO used for the request and result queues.
// No package dependencies.
module ibpm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/ibpm_front.sv @@
// Front end: takes input requests, decodes the opcode and queues the classified request.
// Depends on ibpm_pkg and ibpm_fifo.
module ibpm_front
  import ibpm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  in_item_t  in_data_i,
  input  logic      take_i,
  output q_ctl_t    q_ctl_o,
  output cls_item_t entry_o
);

  cls_item_t cls;
  logic      q_empty;

  always_comb begin
    cls.write_byte  = in_data_i.write_byte;
    cls.ack_to_send = in_data_i.ack_to_send;
    cls.sda_in      = in_data_i.sda_in;
    unique case (in_data_i.opcode) inside
      CMD_START, CMD_STOP, CMD_SEND, CMD_RECV, CMD_SACK, CMD_RACK: begin
        cls.is_cmd = 1'b1;
        cls.cmd    = cmd_e'(in_data_i.opcode);
      end
      // plain tick, opcode seven counts as one too
      default: begin
        cls.is_cmd = 1'b0;
        cls.cmd    = CMD_IDLE;
      end
    endcase
  end

  ibpm_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (DEPTH)
  ) u_req_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i),
    .wr_data_i (cls),
    .rd_en_i   (take_i),
    .rd_data_o (entry_o),
    .full_o    (full_o),
    .empty_o   (q_empty)
  );

  assign q_ctl_o.valid = !q_empty;

endmodule

@@ rtl/ibpm_back.sv @@
// Back end: runs the command phase sequencer on queued requests and queues one result each.
// Depends on ibpm_pkg and ibpm_fifo.
module ibpm_back
  import ibpm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [15:0] phase_ticks_i,
  input  q_ctl_t    q_ctl_i,
  input  cls_item_t entry_i,
  output logic      take_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_data_o
);

  cmd_e        cmd_q, cmd_d;
  logic [4:0]  phase_q, phase_d;
  logic [1:0]  slot_q, slot_d;    // bit slot within the current SDA/SCL/SCL group (SCL/sample/SCL when receiving)
  logic [15:0] tick_q, tick_d;
  logic [7:0]  tx_q, tx_d, rx_q, rx_d;
  logic        ack_q, ack_d, scl_q, scl_d, sda_q, sda_d;
  logic        done, rej;
  logic        out_full;
  logic [15:0] pt;
  logic [16:0] tick_inc;
  logic [4:0]  p_next;
  logic [1:0]  s_next;
  out_item_t   res;

  assign take_o   = q_ctl_i.valid && !out_full;
  assign pt       = (phase_ticks_i == '0) ? 16'd1 : phase_ticks_i;
  assign tick_inc = {1'b0, tick_q} + 17'd1;
  assign p_next   = phase_q + 5'd1;
  assign s_next   = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;

  always_comb begin
    cmd_d   = cmd_q;
    phase_d = phase_q;
    slot_d  = slot_q;
    tick_d  = tick_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (entry_i.is_cmd) begin
      if (cmd_q != CMD_IDLE) begin
        rej = 1'b1;
      end else begin
        cmd_d   = entry_i.cmd;
        phase_d = '0;
        tick_d  = '0;
        slot_d  = 2'd0;
        // first phase acts on the accepting request
        case (entry_i.cmd)
          CMD_STOP: sda_d = 1'b0;
          CMD_SEND: begin
            sda_d = entry_i.write_byte[7];
            tx_d  = {entry_i.write_byte[6:0], 1'b0};
          end
          CMD_RECV: begin
            sda_d  = 1'b1;
            rx_d   = '0;
            slot_d = 2'd2;  // leading SDA release, groups start on the next phase
          end
          CMD_SACK: sda_d = entry_i.ack_to_send;
          default:  sda_d = 1'b1;
        endcase
      end
    end else if (cmd_q != CMD_IDLE) begin
      tick_d = tick_inc[15:0];
      if (tick_inc >= {1'b0, pt}) begin
        tick_d = '0;
        if (phase_q == last_phase(cmd_q)) begin
          cmd_d   = CMD_IDLE;
          phase_d = '0;
          done    = 1'b1;
        end else begin
          phase_d = p_next;
          slot_d  = s_next;
          case (cmd_q)
            CMD_START: begin
              if (p_next == 5'd1) scl_d = 1'b1;
              else if (p_next == 5'd2) sda_d = 1'b0;
              else scl_d = 1'b0;
            end
            CMD_STOP: begin
              if (p_next == 5'd1) scl_d = 1'b1;
              else sda_d = 1'b1;
            end
            CMD_SEND: begin
              if (s_next == 2'd0) begin
                sda_d = tx_q[7];
                tx_d  = {tx_q[6:0], 1'b0};
              end else begin
                scl_d = (s_next == 2'd1);
              end
            end
            CMD_RECV: begin
              if (s_next == 2'd1) rx_d = {rx_q[6:0], entry_i.sda_in};
              else scl_d = (s_next == 2'd0);
            end
            CMD_SACK: scl_d = (p_next == 5'd1);
            CMD_RACK: begin
              if (p_next == 5'd2) ack_d = entry_i.sda_in;
              else scl_d = (p_next == 5'd1);
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    res.scl_level    = scl_d;
    res.sda_level    = sda_d;
    res.busy_res     = (cmd_d != CMD_IDLE);
    res.done_res     = done;
    res.read_byte    = rx_d;
    res.ack_received = ack_d;
    res.rejected     = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_IDLE;
      phase_q <= '0;
      slot_q  <= '0;
      tick_q  <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      ack_q   <= 1'b1;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (take_o) begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      slot_q  <= slot_d;
      tick_q  <= tick_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  ibpm_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (DEPTH)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (take_o),
    .wr_data_i (res),
    .rd_en_i   (pop_i),
    .rd_data_o (out_data_o),
    .full_o    (out_full),
    .empty_o   (empty_o)
  );

endmodule

@@ rtl/i2c_bit_phase_master_core.sv @@
// Top level of the I2C bit-phase master: APB config register, front decoder, back sequencer.
// Depends on ibpm_pkg, ibpm_front, ibpm_back.
//
//   channel   dir  handshake              payload
//   request   in   push / full            in_data_i  (in_item_t)
//   result    out  empty / pop            out_data_o (out_item_t)
//   config    in   APB psel/penable/...   phase_ticks at byte address 0
//
// One request per cycle while the result queue has room; both queues are registered.
// The back sequencer updates its phase state once per request, the only loop.
// Reset empties both queues and restores idle state and phase_ticks = 1.
// A full result queue stalls the sequencer; the request queue then fills and raises full.
module i2c_bit_phase_master_core
  import ibpm_pkg::*;
#(
  parameter int unsigned REQ_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] phase_ticks_q;
  logic        cfg_wr;
  q_ctl_t      q_ctl;
  cls_item_t   entry;
  logic        take;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PHASE_TICKS);
  assign prdata = (paddr[2] == REG_PHASE_TICKS) ? {16'b0, phase_ticks_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 16'd1;
    end else if (cfg_wr) begin
      phase_ticks_q <= pwdata[15:0];
    end
  end

  ibpm_front #(
    .DEPTH (REQ_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_data_i (in_data_i),
    .take_i    (take),
    .q_ctl_o   (q_ctl),
    .entry_o   (entry)
  );

  ibpm_back #(
    .DEPTH (RES_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_ticks_i (phase_ticks_q),
    .q_ctl_i       (q_ctl),
    .entry_i       (entry),
    .take_o        (take),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_data_o    (out_data_o)
  );

endmodule

@@ rtl/ibpm_checker.sv @@
// Port-level checks for the I2C bit-phase master, bound to the top level.
// Depends on ibpm_pkg and i2c_bit_phase_master_core.
module ibpm_checker
  import ibpm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data_o
);

  // a rejected request leaves the running command in place
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.rejected) |-> out_data_o.busy_res)
    else $error("rejected result without busy");

  // finishing a command leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.done_res) |-> !out_data_o.busy_res)
    else $error("done result while still busy");

  a_done_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.done_res) |-> !out_data_o.rejected)
    else $error("done and rejected in one result");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed or vanished");

endmodule

bind i2c_bit_phase_master_core ibpm_checker u_ibpm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

@@ tb/i2c_bit_phase_master_core_tb.sv @@
// Self-checking bench for i2c_bit_phase_master_core: queue-style request/result drivers,
// APB phase_ticks writes, and a cycle-free model of the pin sequencer. Depends on ibpm_pkg.
module i2c_bit_phase_master_core_tb;
  import ibpm_pkg::*;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_TICK_ALT = 3'd7;  // unused opcode, behaves as a tick
  localparam logic [2:0] ADDR_PHASE_TICKS = {REG_PHASE_TICKS, 2'b00};
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    req_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   res_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_bit_phase_master_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (req_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (res_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sequencer model state
  logic [15:0] cfg_ticks = 16'd1;
  cmd_e        cur_cmd = CMD_IDLE;
  logic [4:0]  ph_idx = '0;
  logic [15:0] tick_cnt = '0;
  logic [7:0]  tx_sh = '0;
  logic [7:0]  rx_sh = '0;
  logic        ack_st = 1'b1;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;

  in_item_t  pending_reqs[$];
  out_item_t want_status[$];
  out_item_t next_status;
  out_item_t head_status;

  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_rej = 0;
  int n_done = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int tx_calm = 0;
  int stall_left = 0;
  int rx_calm = 0;
  int hold_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  bit idle_en = 1'b1;

  function automatic int phase_total(cmd_e c);
    case (c)
      CMD_START: return 4;
      CMD_STOP:  return 3;
      CMD_SEND:  return 3 * BITS_PER_BYTE;
      CMD_RECV:  return 1 + 3 * BITS_PER_BYTE;
      CMD_SACK:  return 3;
      CMD_RACK:  return 4;
      default:   return 0;
    endcase
  endfunction

  function automatic void apply_phase(cmd_e c, int p, logic sd, logic ak);
    case (c)
      CMD_START:
        case (p)
          0:       sda_q = 1'b1;
          1:       scl_q = 1'b1;
          2:       sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      CMD_STOP:
        case (p)
          0:       sda_q = 1'b0;
          1:       scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      CMD_SEND:
        case (p % 3)
          0: begin
            sda_q = tx_sh[7];
            tx_sh = {tx_sh[6:0], 1'b0};
          end
          1:       scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      CMD_RECV:
        if (p == 0) begin
          sda_q = 1'b1;  // release SDA before the first read
        end else begin
          case ((p - 1) % 3)
            0:       scl_q = 1'b1;
            1:       rx_sh = {rx_sh[6:0], sd};
            default: scl_q = 1'b0;
          endcase
        end
      CMD_SACK:
        case (p)
          0:       sda_q = ak;
          1:       scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      CMD_RACK:
        case (p)
          0:       sda_q = 1'b1;
          1:       scl_q = 1'b1;
          2:       ack_st = sd;
          default: scl_q = 1'b0;
        endcase
      default: ;
    endcase
  endfunction

  function automatic out_item_t advance_sequencer(in_item_t it);
    out_item_t r;
    logic [15:0] pt;
    logic fin;
    logic rej;
    pt = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
    fin = 1'b0;
    rej = 1'b0;
    if (it.opcode >= CMD_START && it.opcode <= CMD_RACK) begin
      if (cur_cmd != CMD_IDLE) begin
        rej = 1'b1;
      end else begin
        cur_cmd = cmd_e'(it.opcode);
        ph_idx = '0;
        tick_cnt = '0;
        if (cur_cmd == CMD_SEND) tx_sh = it.write_byte;
        if (cur_cmd == CMD_RECV) rx_sh = '0;
        apply_phase(cur_cmd, 0, it.sda_in, it.ack_to_send);
      end
    end else if (cur_cmd != CMD_IDLE) begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= pt) begin
        tick_cnt = '0;
        if (int'(ph_idx) + 1 >= phase_total(cur_cmd)) begin
          cur_cmd = CMD_IDLE;
          ph_idx = '0;
          fin = 1'b1;
        end else begin
          ph_idx = ph_idx + 5'd1;
          apply_phase(cur_cmd, int'(ph_idx), it.sda_in, it.ack_to_send);
        end
      end
    end
    r.scl_level    = scl_q;
    r.sda_level    = sda_q;
    r.busy_res     = (cur_cmd != CMD_IDLE);
    r.done_res     = fin;
    r.read_byte    = rx_sh;
    r.ack_received = ack_st;
    r.rejected     = rej;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_status(input out_item_t got, input out_item_t want);
    if (got.scl_level !== want.scl_level)
      note_mismatch($sformatf("result %0d scl_level %b, want %b", n_res, got.scl_level,
                              want.scl_level));
    if (got.sda_level !== want.sda_level)
      note_mismatch($sformatf("result %0d sda_level %b, want %b", n_res, got.sda_level,
                              want.sda_level));
    if (got.busy_res !== want.busy_res)
      note_mismatch($sformatf("result %0d busy_res %b, want %b", n_res, got.busy_res,
                              want.busy_res));
    if (got.done_res !== want.done_res)
      note_mismatch($sformatf("result %0d done_res %b, want %b", n_res, got.done_res,
                              want.done_res));
    if (got.read_byte !== want.read_byte)
      note_mismatch($sformatf("result %0d read_byte %h, want %h", n_res, got.read_byte,
                              want.read_byte));
    if (got.ack_received !== want.ack_received)
      note_mismatch($sformatf("result %0d ack_received %b, want %b", n_res,
                              got.ack_received, want.ack_received));
    if (got.rejected !== want.rejected)
      note_mismatch($sformatf("result %0d rejected %b, want %b", n_res, got.rejected,
                              want.rejected));
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      req_data <= '0;
    end else begin
      if (push && !full) begin
        next_status = advance_sequencer(req_data);
        if (next_status.rejected) n_rej++;
        if (next_status.done_res) n_done++;
        want_status.push_back(next_status);
        n_req++;
      end
      // a request refused by full stays on the port
      if (!(push && full)) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_data <= pending_reqs.pop_front();
          push <= 1'b1;
          if (tx_calm != 0) begin
            tx_calm--;
          end else if (idle_en && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 17);
            tx_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (want_status.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected", n_res));
        end else begin
          head_status = want_status.pop_front();
          check_status(res_data, head_status);
        end
        n_res++;
      end
      if (hold_seen != hold_asks) begin
        hold_seen++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (rx_calm != 0) begin
          rx_calm--;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 17);
          rx_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic apb_xfer(input logic wr, input logic [31:0] wd, output logic [31:0] rd);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_PHASE_TICKS;
    pwdata <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_phase_ticks(input logic [31:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, val, rd);
    cfg_ticks = val[15:0];
    apb_xfer(1'b0, '0, rd);
    if (rd[15:0] !== cfg_ticks)
      note_mismatch($sformatf("phase_ticks reads %h, want %h", rd[15:0], cfg_ticks));
  endtask

  task automatic add_req(input logic [2:0] op, input logic [7:0] wb, input logic ak,
                         input logic sd);
    in_item_t it;
    it.opcode = op;
    it.write_byte = wb;
    it.ack_to_send = ak;
    it.sda_in = sd;
    pending_reqs.push_back(it);
  endtask

  task automatic add_rand(input logic [2:0] op);
    add_req(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
  endtask

  function automatic logic [2:0] tick_op();
    return ($urandom_range(0, 9) == 0) ? OP_TICK_ALT : OP_TICK;
  endfunction

  // mostly complete command sequences with random content; some rejected commands
  // mid-sequence, stray idle ticks, and cut-short sequences fed random opcodes
  task automatic gen_traffic(input int n);
    int cnt;
    int need;
    int eff;
    int pick;
    cmd_e c;
    eff = (cfg_ticks == 16'd0) ? 1 : int'(cfg_ticks);
    cnt = 0;
    while (cnt < n) begin
      c = cmd_e'(3'($urandom_range(1, 6)));
      need = phase_total(c) * eff;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        add_rand(c);
        cnt++;
        repeat (need) begin
          if ($urandom_range(0, 29) == 0) begin
            add_rand(3'($urandom_range(1, 6)));
            cnt++;
          end
          add_rand(tick_op());
          cnt++;
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) begin
          add_rand(tick_op());
          cnt++;
        end
      end else begin
        add_rand(c);
        cnt++;
        repeat ($urandom_range(1, need)) begin
          add_rand(3'($urandom_range(0, 7)));
          cnt++;
        end
      end
    end
    // finish whatever command is still open so the next register write sees an idle block
    repeat (phase_total(CMD_RECV) * eff) add_rand(OP_TICK);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || push || want_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] rd;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_xfer(1'b0, '0, rd);
    if (rd[15:0] !== 16'd1)
      note_mismatch($sformatf("phase_ticks after reset reads %h, want 0001", rd[15:0]));

    // directed: idle ticks, busy rejection, both ack levels, ack sampling
    add_req(OP_TICK, 8'h00, 1'b0, 1'b0);
    add_req(OP_TICK_ALT, 8'hFF, 1'b1, 1'b1);
    add_req(CMD_START, 8'h00, 1'b0, 1'b0);
    add_req(CMD_STOP, 8'hFF, 1'b1, 1'b1);
    repeat (4) add_req(OP_TICK, 8'h00, 1'b0, 1'b1);
    add_req(CMD_SACK, 8'h00, 1'b1, 1'b0);
    repeat (3) add_req(OP_TICK, 8'h00, 1'b0, 1'b0);
    add_req(CMD_SACK, 8'hFF, 1'b0, 1'b1);
    repeat (3) add_req(OP_TICK_ALT, 8'h00, 1'b1, 1'b0);
    add_req(CMD_RACK, 8'h00, 1'b0, 1'b1);
    repeat (4) add_req(OP_TICK, 8'h00, 1'b0, 1'b0);
    add_req(CMD_STOP, 8'h00, 1'b0, 1'b0);
    repeat (3) add_req(OP_TICK, 8'h00, 1'b0, 1'b1);
    wait_drained();

    set_phase_ticks(32'h0000_0000);  // zero counts as one
    gen_traffic(220);
    wait_drained();

    set_phase_ticks(32'hFFFF_0002);  // upper bits beyond the register are dropped
    hold_asks++;
    gen_traffic(220);
    wait_drained();

    set_phase_ticks(32'd3);
    gen_traffic(220);
    wait_drained();

    set_phase_ticks(32'd1);
    gen_traffic(220);
    wait_drained();

    set_phase_ticks(32'd7);
    gen_traffic(220);
    wait_drained();

    // longest phase, full rate on both sides from here to the end
    idle_en = 1'b0;
    set_phase_ticks(32'h0000_FFFF);
    add_rand(CMD_STOP);
    for (int k = 0; k < 150; k++) begin
      if (k == 100) add_rand(CMD_RECV);
      add_rand((k == 120) ? OP_TICK_ALT : OP_TICK);
    end
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (want_status.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", want_status.size()));
    $display("Ran %0d requests (%0d rejected, %0d commands completed), %0d results checked,",
             n_req, n_rej, n_done, n_res);
    $display("over phase_ticks 0, 1, 2, 3, 7 and 65535 with one long result hold-off.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
